>>> hw/rtl/lsfd_pkg.sv
package lsfd_pkg;

	localparam int WindowLen   = 100;
	localparam int MonEntries  = 16;
	localparam int FlowBits    = 16;
	localparam int WinIdxW     = $clog2(WindowLen);
	localparam int WinCntW     = $clog2(WindowLen + 1);
	localparam int MonIdxW     = (MonEntries > 1) ? $clog2(MonEntries) : 1;
	localparam int QueueDepth  = 2;

	localparam logic [15:0] WeightReset    = 16'd6554;
	localparam logic [15:0] TriggerReset   = 16'd39322;
	localparam logic [15:0] ThresholdReset = 16'd52429;

	typedef enum logic [1:0] {
		REQ_SATISFIED = 2'd0,
		REQ_EXPIRED   = 2'd1,
		REQ_QUERY     = 2'd2,
		REQ_UNUSED    = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		CFG_WEIGHT    = 2'd0,
		CFG_TRIGGER   = 2'd1,
		CFG_THRESHOLD = 2'd2,
		CFG_NONE      = 2'd3
	} cfg_index_t;

	// classified event passed from front to back
	typedef struct packed {
		logic                is_query;
		logic                is_update;
		logic                loss;
		logic [FlowBits-1:0] flow;
	} event_t;

	typedef struct packed {
		logic        is_suspect;
		logic        defer_to_base;
		logic        newly_monitored;
		logic [15:0] new_flow_id;
		logic        table_full_drop;
		logic [15:0] total_loss;
	} result_t;

endpackage

>>> hw/rtl/lsfd_if.sv
interface lsfd_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [15:0] flow_id;
	logic        was_rejected;
	modport source (output valid, req_type, flow_id, was_rejected, input ready);
	modport sink (input valid, req_type, flow_id, was_rejected, output ready);
endinterface

interface lsfd_rsp_if;
	logic        valid;
	logic        ready;
	logic        is_suspect;
	logic        defer_to_base;
	logic        newly_monitored;
	logic [15:0] new_flow_id;
	logic        table_full_drop;
	logic [15:0] total_loss;
	modport source (output valid, is_suspect, defer_to_base, newly_monitored, new_flow_id,
		table_full_drop, total_loss, input ready);
	modport sink (input valid, is_suspect, defer_to_base, newly_monitored, new_flow_id,
		table_full_drop, total_loss, output ready);
endinterface

interface lsfd_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/lsfd_front.sv
module lsfd_front (
	input  logic                  clk,
	input  logic                  arst_n,
	lsfd_req_if.sink              req,
	output logic                  ev_valid,
	input  logic                  ev_ready,
	output lsfd_pkg::event_t      ev
);
	// small fifo between classifier and engine
	lsfd_pkg::event_t fifo_q [lsfd_pkg::QueueDepth];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	lsfd_pkg::event_t cls;
	logic push, pop;

	always_comb begin
		cls.flow      = req.flow_id[lsfd_pkg::FlowBits-1:0];
		cls.is_query  = (req.req_type == lsfd_pkg::REQ_QUERY);
		cls.loss      = (req.req_type == lsfd_pkg::REQ_EXPIRED);
		cls.is_update = (req.req_type == lsfd_pkg::REQ_SATISFIED) ||
			((req.req_type == lsfd_pkg::REQ_EXPIRED) && !req.was_rejected);
	end

	assign req.ready = (count_q != 2'd2);
	assign push = req.valid && req.ready;
	assign ev_valid = (count_q != 2'd0);
	assign pop = ev_valid && ev_ready;
	assign ev = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

>>> hw/rtl/lsfd_back.sv
module lsfd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  ev_valid,
	output logic                  ev_ready,
	input  lsfd_pkg::event_t      ev,
	input  logic [15:0]           weight,
	input  logic [15:0]           trigger,
	input  logic [15:0]           threshold,
	lsfd_rsp_if.source            rsp
);
	localparam int WL = lsfd_pkg::WindowLen;
	localparam int ME = lsfd_pkg::MonEntries;
	localparam int FB = lsfd_pkg::FlowBits;
	localparam int IW = lsfd_pkg::WinIdxW;
	localparam int CW = lsfd_pkg::WinCntW;
	localparam int MW = lsfd_pkg::MonIdxW;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_LOOK  = 7'b0000010,
		ST_MUL   = 7'b0000100,
		ST_UPD   = 7'b0001000,
		ST_SCANO = 7'b0010000,
		ST_SCANI = 7'b0100000,
		ST_PICK  = 7'b1000000
	} state_t;

	state_t state_q;
	lsfd_pkg::event_t ev_q;
	logic [FB-1:0] win_mem [WL];
	logic [IW-1:0] head_q;
	logic [CW-1:0] fill_q;
	logic [ME-1:0] mvalid_q;
	logic [FB-1:0] mflow_q [ME];
	logic [15:0]   mrate_q [ME];
	logic [15:0]   total_q;
	logic          hit_q;
	logic [MW-1:0] slot_q;
	logic [15:0]   old_q;
	logic [32:0]   prod_q;
	logic [IW-1:0] i_q, j_q, start_q;
	logic [FB-1:0] v_q, rd_q, best_q;
	logic [CW-1:0] cnt_q, bestcnt_q;
	logic          rd_v_q;
	logic          out_valid_q;
	lsfd_pkg::result_t out_q;

	// flow table search
	logic          hit_c;
	logic [MW-1:0] hit_idx_c;
	logic          free_c;
	logic [MW-1:0] free_idx_c;
	logic [FB-1:0] key_c;
	always_comb begin
		key_c = state_q[6] ? best_q : ev_q.flow;
		hit_c = 1'b0; hit_idx_c = '0; free_c = 1'b0; free_idx_c = '0;
		for (int k = ME - 1; k >= 0; k--) begin
			if (mvalid_q[k] && mflow_q[k] == key_c) begin
				hit_c = 1'b1; hit_idx_c = MW'(k);
			end
			if (!mvalid_q[k]) begin
				free_c = 1'b1; free_idx_c = MW'(k);
			end
		end
	end

	// blend: (65536-w)*old + 32768 + loss*w*65536, >>16, saturate
	logic [16:0] inv_w;
	logic [33:0] acc_c;
	logic [17:0] sh_c;
	logic [15:0] blend_c;
	assign inv_w = 17'h10000 - {1'b0, weight};
	assign acc_c = {1'b0, prod_q} + 34'd32768 + (ev_q.loss ? {2'b0, weight, 16'b0} : 34'd0);
	assign sh_c = acc_c[33:16];
	assign blend_c = (sh_c > 18'd65535) ? 16'hFFFF : sh_c[15:0];

	// search starts on a loss that leaves the total above the trigger with a full window
	logic trig_c;
	assign trig_c = ev_q.loss && (fill_q == CW'(WL)) &&
		((hit_q ? total_q : blend_c) > trigger);

	logic [IW:0]   rd_sum_c;
	logic [IW-1:0] rd_addr_c;
	assign rd_sum_c = {1'b0, start_q} + {1'b0, j_q};
	assign rd_addr_c = (rd_sum_c >= (IW+1)'(WL)) ? IW'(rd_sum_c - (IW+1)'(WL)) :
		rd_sum_c[IW-1:0];

	logic out_free;
	assign out_free = !out_valid_q || rsp.ready;
	assign ev_ready = state_q[0];

	// a new result enters the output register this cycle
	logic out_load_c;
	assign out_load_c = out_free && ((state_q[1] && !ev_q.is_update) ||
		(state_q[3] && !trig_c) || state_q[6]);

	logic [IW-1:0] inext;
	assign inext = IW'(i_q + 1'b1);

	always_ff @(posedge clk) begin
		if (state_q[0] && ev_valid && ev.is_update) begin
			win_mem[head_q] <= ev.flow;
		end
		rd_q <= win_mem[rd_addr_c];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			fill_q      <= '0;
			mvalid_q    <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			rd_v_q      <= 1'b0;
		end else begin
			if (rsp.ready && !out_load_c) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (ev_valid) begin
						ev_q <= ev;
						if (ev.is_update) begin
							head_q <= (head_q == IW'(WL - 1)) ? '0 : IW'(head_q + 1'b1);
							if (fill_q != CW'(WL)) fill_q <= CW'(fill_q + 1'b1);
						end
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					hit_q  <= hit_c;
					slot_q <= hit_idx_c;
					old_q  <= hit_c ? mrate_q[hit_idx_c] : total_q;
					if (ev_q.is_update) state_q <= ST_MUL;
					else if (out_free) begin
						out_valid_q <= 1'b1;
						out_q <= '{is_suspect: ev_q.is_query && hit_c &&
								mrate_q[hit_idx_c] > threshold,
							defer_to_base: !(hit_c && mrate_q[hit_idx_c] > threshold) &&
								ev_q.is_query,
							newly_monitored: 1'b0, new_flow_id: 16'd0,
							table_full_drop: 1'b0, total_loss: total_q};
						state_q <= ST_IDLE;
					end
				end
				ST_MUL: begin
					prod_q  <= inv_w * old_q;
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (hit_q) mrate_q[slot_q] <= blend_c;
					else total_q <= blend_c;
					if (trig_c) begin
						// window full: oldest entry is at head
						start_q   <= head_q;
						i_q       <= '0;
						j_q       <= '0;
						bestcnt_q <= '0;
						best_q    <= '0;
						state_q   <= ST_SCANO;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						out_q <= '{1'b0, 1'b0, 1'b0, 16'd0, 1'b0,
							hit_q ? total_q : blend_c};
						state_q <= ST_IDLE;
					end else begin
						// hold result until output frees; total now updated
						hit_q   <= 1'b1;
						slot_q  <= slot_q;
						old_q   <= old_q;
						state_q <= ST_PICK;
						ev_q.loss <= 1'b0;
						ev_q.is_query <= 1'b1;
					end
				end
				ST_SCANO: begin
					// fetch v = entry i
					rd_v_q <= !rd_v_q && (j_q == i_q);
					if (rd_v_q) begin
						v_q   <= rd_q;
						cnt_q <= '0;
						j_q   <= '0;
						state_q <= ST_SCANI;
					end
				end
				ST_SCANI: begin
					// count matches among entries 0..i, one memory read at a time
					rd_v_q <= !rd_v_q;
					if (rd_v_q) begin
						if (rd_q == v_q) cnt_q <= CW'(cnt_q + 1'b1);
						if (j_q == i_q) begin
							if (CW'(cnt_q + (rd_q == v_q)) > bestcnt_q) begin
								bestcnt_q <= CW'(cnt_q + (rd_q == v_q));
								best_q    <= v_q;
							end
							if (i_q == IW'(WL - 1)) begin
								ev_q.is_query <= 1'b0;
								state_q <= ST_PICK;
							end else begin
								i_q <= inext;
								j_q <= inext;
								state_q <= ST_SCANO;
							end
						end else begin
							j_q <= IW'(j_q + 1'b1);
						end
					end
				end
				ST_PICK: begin
					if (ev_q.is_query) begin
						// stalled plain update result
						if (out_free) begin
							out_valid_q <= 1'b1;
							out_q <= '{1'b0, 1'b0, 1'b0, 16'd0, 1'b0, total_q};
							state_q <= ST_IDLE;
						end
					end else if (out_free) begin
						if (hit_c) mrate_q[hit_idx_c] <= '0;
						else if (free_c) begin
							mvalid_q[free_idx_c] <= 1'b1;
							mflow_q[free_idx_c]  <= best_q;
							mrate_q[free_idx_c]  <= '0;
						end
						total_q <= '0;
						fill_q  <= '0;
						head_q  <= '0;
						out_valid_q <= 1'b1;
						out_q <= '{1'b0, 1'b0, !hit_c && free_c, 16'(best_q), !hit_c && !free_c,
							16'd0};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.is_suspect      = out_q.is_suspect;
	assign rsp.defer_to_base   = out_q.defer_to_base;
	assign rsp.newly_monitored = out_q.newly_monitored;
	assign rsp.new_flow_id     = out_q.new_flow_id;
	assign rsp.table_full_drop = out_q.table_full_drop;
	assign rsp.total_loss      = out_q.total_loss;
endmodule

>>> hw/rtl/loss_driven_suspect_flow_detector.sv
// Loss-driven suspect flow detector.
// Channels: req (req_type, flow_id, was_rejected) in, rsp (one result per
// request) out, cfg (index, data) for the three Q0.16 registers: average
// weight, loss trigger and suspect threshold.
// A front stage classifies each request into a two-entry queue; a back
// engine runs it: table lookup, multiply and average update for a satisfied
// or non-rejected expired event, then result; any other request only passes
// take and lookup. The engine takes a new request only once back in idle.
// A loss search scans the 100-entry window one memory read at a time,
// comparing each entry against itself and all older ones, then a pick step;
// no request leaves the queue meanwhile.
// Reset clears the window count, head, monitored valid bits, total loss and
// restores register defaults; no clearing pass is needed.
// When the receiver stalls, the result holds in the output register and the
// engine waits; the queue keeps accepting requests until it fills.
// Configure only while the block is idle.
module loss_driven_suspect_flow_detector (
	input  logic         clk,
	input  logic         arst_n,
	lsfd_req_if.sink     req,
	lsfd_rsp_if.source   rsp,
	lsfd_cfg_if.sink     cfg
);
	logic [15:0] weight_q, trigger_q, threshold_q;
	logic ev_valid, ev_ready;
	lsfd_pkg::event_t ev;

	// registers always take a write request
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q    <= lsfd_pkg::WeightReset;
			trigger_q   <= lsfd_pkg::TriggerReset;
			threshold_q <= lsfd_pkg::ThresholdReset;
		end else if (cfg.valid) begin
			case (cfg.index)
				lsfd_pkg::CFG_WEIGHT:    weight_q    <= cfg.data;
				lsfd_pkg::CFG_TRIGGER:   trigger_q   <= cfg.data;
				lsfd_pkg::CFG_THRESHOLD: threshold_q <= cfg.data;
				default: ;
			endcase
		end
	end

	lsfd_front u_front (
		.clk(clk), .arst_n(arst_n), .req(req),
		.ev_valid(ev_valid), .ev_ready(ev_ready), .ev(ev)
	);

	lsfd_back u_back (
		.clk(clk), .arst_n(arst_n),
		.ev_valid(ev_valid), .ev_ready(ev_ready), .ev(ev),
		.weight(weight_q), .trigger(trigger_q), .threshold(threshold_q),
		.rsp(rsp)
	);
endmodule
